FILE: rtl/core/skht_pkg.sv
package skht_pkg;

  // table geometry
  localparam int CAPACITY = 16;
  localparam int AddrW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW     = $clog2(CAPACITY + 1);

  // field widths
  localparam int KeyW    = 64;
  localparam int RefW    = 16;
  localparam int StatusW = 3;
  localparam int CountW  = 5;

  // request kinds
  localparam logic REQ_LOOKUP   = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_FOUND    = 3'd0,
    STAT_MISSING  = 3'd1,
    STAT_INSERTED = 3'd2,
    STAT_UPDATED  = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  // one stored table entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [RefW-1:0] load_ref;
    logic [RefW-1:0] free_ref;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // one request word
  typedef struct packed {
    logic            req_type;
    logic [KeyW-1:0] key;
    logic [RefW-1:0] load_ref;
    logic [RefW-1:0] free_ref;
  } req_t;

  // one result word
  typedef struct packed {
    status_e           status;
    logic [RefW-1:0]   found_load_ref;
    logic [RefW-1:0]   found_free_ref;
    logic [CountW-1:0] entry_count;
  } res_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/core/skht_ram.sv
module skht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/skht_ctrl.sv
module skht_ctrl import skht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  state_e state_q, state_d;

  // request being served
  req_t            cur_q, cur_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] mid_q, mid_d;
  logic [CntW-1:0] idx_q, idx_d;
  status_e         stat_q, stat_d;
  logic [RefW-1:0] out_l_q, out_l_d;
  logic [RefW-1:0] out_f_q, out_f_d;

  // table memory port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;

  // shared compare unit and search helpers
  logic            key_less;
  logic            key_equal;
  logic [CntW-1:0] mid;
  logic            range_open;
  logic            resolve;
  logic            hit;
  logic            full;
  logic            need_shift;
  logic [RefW-1:0] upd_l;
  logic [RefW-1:0] upd_f;

  skht_ram #(
    .Width (EntryW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // compare stored key against the request key
  assign key_less  = ram_rdata.key < cur_q.key;
  assign key_equal = ram_rdata.key == cur_q.key;

  // search window midpoint
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign range_open = lo_q < hi_q;

  // search outcome is known either at an empty window past the end or after the final check
  assign resolve = (state_q == ST_PROBE && !range_open && !(lo_q < used_q)) ||
                   (state_q == ST_CHECK);
  assign hit        = (state_q == ST_CHECK) && key_equal;
  assign full       = used_q == CntW'(CAPACITY);
  assign need_shift = resolve && !hit && (cur_q.req_type == REQ_REGISTER) && !full;

  // merged references for an update
  assign upd_l = (cur_q.load_ref != '0) ? cur_q.load_ref : ram_rdata.load_ref;
  assign upd_f = (cur_q.free_ref != '0) ? cur_q.free_ref : ram_rdata.free_ref;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (range_open) begin
          state_d = ST_COMPARE;
        end else if (lo_q < used_q) begin
          state_d = ST_CHECK;
        end else if (need_shift) begin
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COMPARE: state_d = ST_PROBE;
      ST_CHECK: begin
        state_d = need_shift ? ST_SHIFT_RD : ST_DONE;
      end
      ST_SHIFT_RD: begin
        state_d = (idx_q > lo_q) ? ST_SHIFT_WR : ST_DONE;
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    ram_we      = 1'b0;
    ram_waddr   = lo_q[AddrW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = lo_q[AddrW-1:0];
    cur_d       = cur_q;
    used_d      = used_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    out_l_d     = out_l_q;
    out_f_d     = out_f_q;

    case (state_q)
      ST_IDLE: begin
        cur_d = req_i;
        lo_d  = '0;
        hi_d  = used_q;
      end
      ST_PROBE: begin
        // read the midpoint, or the final candidate once the window closes
        if (range_open) begin
          ram_raddr = mid[AddrW-1:0];
          mid_d     = mid;
        end else begin
          ram_raddr = lo_q[AddrW-1:0];
        end
      end
      ST_COMPARE: begin
        if (key_less) begin
          lo_d = mid_q + CntW'(1);
        end else begin
          hi_d = mid_q;
        end
      end
      ST_CHECK: begin
        // update in place on a register hit
        if (hit && cur_q.req_type == REQ_REGISTER) begin
          ram_we    = 1'b1;
          ram_waddr = lo_q[AddrW-1:0];
          ram_wdata = '{key: ram_rdata.key, load_ref: upd_l, free_ref: upd_f};
        end
      end
      ST_SHIFT_RD: begin
        if (idx_q > lo_q) begin
          ram_raddr = AddrW'(idx_q - CntW'(1));
        end else begin
          // drop the new entry into the gap
          ram_we    = 1'b1;
          ram_waddr = lo_q[AddrW-1:0];
          ram_wdata = '{key: cur_q.key, load_ref: cur_q.load_ref,
                        free_ref: cur_q.free_ref};
          used_d    = used_q + CntW'(1);
          stat_d    = STAT_INSERTED;
          out_l_d   = cur_q.load_ref;
          out_f_d   = cur_q.free_ref;
        end
      end
      ST_SHIFT_WR: begin
        // move one entry up a slot
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_q - CntW'(1);
      end
      default: ;
    endcase

    // settle the result of the search
    if (resolve) begin
      idx_d   = used_q;
      out_l_d = '0;
      out_f_d = '0;
      if (cur_q.req_type == REQ_LOOKUP) begin
        if (hit) begin
          stat_d  = STAT_FOUND;
          out_l_d = ram_rdata.load_ref;
          out_f_d = ram_rdata.free_ref;
        end else begin
          stat_d = STAT_MISSING;
        end
      end else if (hit) begin
        stat_d  = STAT_UPDATED;
        out_l_d = upd_l;
        out_f_d = upd_f;
      end else if (full) begin
        stat_d = STAT_FULL;
      end
    end
  end

  assign res_o = '{status: stat_q, found_load_ref: out_l_q, found_free_ref: out_f_q,
                   entry_count: CountW'(used_q)};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    idx_q   <= idx_d;
    stat_q  <= stat_d;
    out_l_q <= out_l_d;
    out_f_q <= out_f_d;
  end

  // the entry count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // the entry count only grows, one entry at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && used_q != $past(used_q)) |->
      (used_q == $past(used_q) + CntW'(1)))
    else $error("entry count changed by other than one");

  // a compare step always follows a probe read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPARE) |-> ($past(state_q) == ST_PROBE))
    else $error("compare without probe");

  // the search window stays ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (lo_q <= hi_q && hi_q <= used_q))
    else $error("search window out of order");

  // the table is never written while idle or when a full table rejects
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CHECK || state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR))
    else $error("table write outside update or insert");

endmodule

FILE: rtl/core/sorted_key_handler_table.sv
// Sorted key table: holds up to CAPACITY entries ordered by 64-bit key, each
// with a load and a free handler reference.
// Input stream: s_axis_tuser selects lookup (0) or register (1); s_axis_tdata
// carries key, load_ref and free_ref. Each word yields exactly one result word.
// Output stream: m_axis_tuser is the status (found, not found, inserted,
// updated, full); m_axis_tdata carries the references and the entry count.
// Steps: a search makes at most floor(log2(entry count)) + 1 probes, each a
// probe read and a compare, then a closing probe read, a check read when the
// window ends inside the table, and the result state; the result then passes
// through the output register to m_axis, and the next word is taken once the
// sequencer is idle again. An insert then moves each entry above the new key
// up one slot, a read and a write per entry, and writes the new entry into
// the gap. The table memory has one write port and one registered read port.
// One word is worked on at a time; s_axis_tready is high only when idle.
// The result goes into an output register, so the next input word is taken
// while a result still waits there; a stalled receiver holds the next result
// in the sequencer until the output register frees up.
// Reset empties the table at once (entry count to zero); no clearing pass.
module sorted_key_handler_table import skht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // key[63:0], load_ref[79:64], free_ref[95:80]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // found_load_ref[15:0], found_free_ref[31:16],
                                     // entry_count[36:32], zero[39:37]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid_q;
  res_t out_q;

  // unpack the request word
  assign req = '{req_type: s_axis_tuser[0], key: s_axis_tdata[63:0],
                 load_ref: s_axis_tdata[79:64], free_ref: s_axis_tdata[95:80]};

  skht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // pack the result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {3'b000, out_q.entry_count, out_q.found_free_ref,
                          out_q.found_load_ref};

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import skht_pkg::*;

  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 80;

  // expected reply of the table for one request word
  typedef struct packed {
    status_e           status;
    logic [RefW-1:0]   load_ref;
    logic [RefW-1:0]   free_ref;
    logic [CountW-1:0] count;
  } reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;  // key[63:0], load_ref[79:64], free_ref[95:80]
  logic [0:0]  s_axis_tuser  = '0;  // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // found_load_ref[15:0], found_free_ref[31:16],
                                    // entry_count[36:32], zero[39:37]
  logic [2:0]  m_axis_tuser;        // status[2:0]

  // shadow copy of the sorted table
  logic [KeyW-1:0] shadow_key  [CAPACITY];
  logic [RefW-1:0] shadow_load [CAPACITY];
  logic [RefW-1:0] shadow_free [CAPACITY];
  int unsigned     shadow_used = 0;

  reply_t      replies_due[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  sorted_key_handler_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // binary search plus sorted insert / in-place update on the shadow table
  function automatic reply_t apply_request(logic req, logic [KeyW-1:0] k,
                                           logic [RefW-1:0] ld, logic [RefW-1:0] fr);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    bit          hit;
    reply_t      r;
    lo = 0;
    hi = shadow_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < shadow_used) && (shadow_key[lo] == k);
    r.load_ref = '0;
    r.free_ref = '0;
    if (req == REQ_LOOKUP) begin
      if (hit) begin
        r.status   = STAT_FOUND;
        r.load_ref = shadow_load[lo];
        r.free_ref = shadow_free[lo];
      end else begin
        r.status = STAT_MISSING;
      end
    end else if (hit) begin
      // zero reference leaves the stored one alone
      if (ld != '0) shadow_load[lo] = ld;
      if (fr != '0) shadow_free[lo] = fr;
      r.status   = STAT_UPDATED;
      r.load_ref = shadow_load[lo];
      r.free_ref = shadow_free[lo];
    end else if (shadow_used >= CAPACITY) begin
      r.status = STAT_FULL;
    end else begin
      for (i = shadow_used; i > lo; i--) begin
        shadow_key[i]  = shadow_key[i-1];
        shadow_load[i] = shadow_load[i-1];
        shadow_free[i] = shadow_free[i-1];
      end
      shadow_key[lo]  = k;
      shadow_load[lo] = ld;
      shadow_free[lo] = fr;
      shadow_used++;
      r.status   = STAT_INSERTED;
      r.load_ref = ld;
      r.free_ref = fr;
    end
    r.count = CountW'(shadow_used);
    return r;
  endfunction

  // offer one request word, wait for it to be taken, then predict its reply
  task automatic send_request(logic req, logic [KeyW-1:0] k,
                              logic [RefW-1:0] ld, logic [RefW-1:0] fr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fr, ld, k};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    replies_due.push_back(apply_request(req, k, ld, fr));
  endtask

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // zero and all-ones show up often, they steer the update rules
  function automatic logic [RefW-1:0] random_ref();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return '0;
    if (pick < 35) return '1;
    return RefW'($urandom_range(65535));
  endfunction

  function automatic logic [KeyW-1:0] known_key();
    if (shadow_used == 0) return random_key();
    return shadow_key[$urandom_range(shadow_used - 1)];
  endfunction

  function automatic logic [KeyW-1:0] near_key();
    return known_key() + ($urandom_range(1) ? 64'd1 : -64'd1);
  endfunction

  // mostly hits and updates on stored keys, the rest misses and overflow
  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      send_request(REQ_LOOKUP, known_key(), random_ref(), random_ref());
    else if (pick < 50) send_request(REQ_LOOKUP, near_key(), random_ref(), random_ref());
    else if (pick < 55) send_request(REQ_LOOKUP, random_key(), random_ref(), random_ref());
    else if (pick < 85) send_request(REQ_REGISTER, known_key(), random_ref(), random_ref());
    else if (pick < 95) send_request(REQ_REGISTER, random_key(), random_ref(), random_ref());
    else                send_request(REQ_REGISTER, near_key(), random_ref(), random_ref());
  endtask

  task automatic test_lookup_empty();
    send_request(REQ_LOOKUP, '0, '0, '0);
    send_request(REQ_LOOKUP, '1, '1, '1);
  endtask

  // inserts at the middle, front, back and between existing keys
  task automatic test_insert_positions();
    send_request(REQ_REGISTER, 64'h8000_0000_0000_0000, 16'hFFFF, 16'hFFFF);
    send_request(REQ_REGISTER, 64'h0, 16'h0000, 16'h0000);
    send_request(REQ_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 16'h8000);
    send_request(REQ_REGISTER, 64'h7FFF_FFFF_FFFF_FFFF, 16'hAAAA, 16'h5555);
    send_request(REQ_LOOKUP, 64'h0, 16'h0, 16'h0);
    send_request(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0);
    send_request(REQ_LOOKUP, 64'h8000_0000_0000_0001, 16'h0, 16'h0);
    send_request(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE, 16'h0, 16'h0);
  endtask

  // only load, only free, neither, both
  task automatic test_update_rules();
    send_request(REQ_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 16'h0000);
    send_request(REQ_REGISTER, 64'h0, 16'h0000, 16'h4321);
    send_request(REQ_REGISTER, 64'h8000_0000_0000_0000, 16'h0000, 16'h0000);
    send_request(REQ_REGISTER, 64'h7FFF_FFFF_FFFF_FFFF, 16'hBEEF, 16'hCAFE);
    send_request(REQ_LOOKUP, 64'h8000_0000_0000_0000, 16'h0, 16'h0);
  endtask

  // random keys land at random sorted positions until the table is full
  task automatic test_fill_to_capacity();
    while (shadow_used < CAPACITY)
      send_request(REQ_REGISTER, random_key(), random_ref(), random_ref());
    send_request(REQ_REGISTER, random_key(), 16'h1111, 16'h2222);
    send_request(REQ_REGISTER, known_key(), 16'h3333, 16'h4444);
    send_request(REQ_LOOKUP, near_key(), 16'h0, 16'h0);
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_receiver_hold();
    hold_request = 1'b1;
    repeat (40) random_request();
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned n_words);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_words) random_request();
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // reply checker and receiver ready, with its own hold-off counter
  always @(posedge clk_i) begin : rx_side
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected reply, expected none, actual status %0d data 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = replies_due.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("found_load_ref", want.load_ref, m_axis_tdata[15:0]);
        check_field("found_free_ref", want.free_ref, m_axis_tdata[31:16]);
        check_field("entry_count", want.count, m_axis_tdata[36:32]);
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 60;
    test_lookup_empty();
    test_insert_positions();
    test_update_rules();
    test_fill_to_capacity();
    test_receiver_hold();
    test_random_traffic(12, 60, 620);
    test_random_traffic(60, 12, 620);
    test_random_traffic(0, 0, 620);
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sorted_key_handler_table.f
rtl/core/skht_pkg.sv
rtl/core/skht_ram.sv
rtl/core/skht_ctrl.sv
rtl/core/sorted_key_handler_table.sv
tb/sv/tb.sv
